// ===== design/voice_frame_light_controller_assert.svh =====
// Assertion macros used by the voice frame light controller checker.
`ifndef VOICE_FRAME_LIGHT_CONTROLLER_ASSERT_SVH
`define VOICE_FRAME_LIGHT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define VFLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice frame light controller check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define VFLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice frame light controller check failed");

`endif

// ===== design/vflc_pkg.sv =====
// Types and constants of the voice frame light controller.
package vflc_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h5A;
  localparam logic [2:0] FRAME_LAST = 3'd4;

  localparam logic [7:0] CMD_WAKE       = 8'h00;
  localparam logic [7:0] CMD_EXIT       = 8'h01;
  localparam logic [7:0] CMD_FIRST_ON_A = 8'h27;
  localparam logic [7:0] CMD_BOTH_OFF   = 8'h28;
  localparam logic [7:0] CMD_FIRST_ON_B = 8'h29;
  localparam logic [7:0] CMD_FIRST_OFF  = 8'h2A;
  localparam logic [7:0] CMD_BOTH_ON    = 8'h2B;
  localparam logic [7:0] CMD_SECOND_OFF = 8'h2C;

  localparam int CFG_ADDR_W = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_ACTIVE_LOW_FIRST  = 1'b0;
  localparam logic REG_ACTIVE_LOW_SECOND = 1'b1;

  typedef enum logic [1:0] {
    STATUS_LIGHT     = 2'd0,
    STATUS_NOTICE    = 2'd1,
    STATUS_UNKNOWN   = 2'd2,
    STATUS_CSUM_FAIL = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic active_low_first;
    logic active_low_second;
  } vflc_cfg_t;

  typedef struct packed {
    frame_status_t frame_status;
    logic [7:0]    command_code;
    logic          first_on;
    logic          second_on;
    logic          first_pin_level;
    logic          second_pin_level;
    logic          state_changed;
  } vflc_result_t;

endpackage

// ===== design/vflc_if.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
interface vflc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface vflc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [7:0] command_code;
  logic       first_on;
  logic       second_on;
  logic       first_pin_level;
  logic       second_pin_level;
  logic       state_changed;

  modport source (
    output valid, output frame_status, output command_code, output first_on,
    output second_on, output first_pin_level, output second_pin_level,
    output state_changed, input ready
  );
  modport sink (
    input valid, input frame_status, input command_code, input first_on,
    input second_on, input first_pin_level, input second_pin_level,
    input state_changed, output ready
  );
endinterface

// ===== design/voice_frame_light_controller.sv =====
// Top level of the voice frame light controller.
//
//   channel   dir  transfer when         payload
//   in_ch     in   valid && ready        rx_byte
//   out_ch    out  valid && ready        frame_status, command_code, first_on,
//                                        second_on, first_pin_level,
//                                        second_pin_level, state_changed
//   apb       in   psel&penable&pwrite   active_low_first (0x0), active_low_second (0x4)
//
// One byte per cycle while in_ch.ready is high. A frame's fifth byte yields its result
// through the result register, or the skid entry while out_ch is stalled; all other bytes yield nothing.
// rst (synchronous) clears frame tracking, both lights and the output stage,
// and sets the polarities to first active low, second active high.
// A stalled result is held in the result register; one more result fits in the
// skid entry, and in_ch.ready drops only while that entry is full.
module voice_frame_light_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vflc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  vflc_in_if.sink                         in_ch,
  vflc_out_if.source                      out_ch
);
  import vflc_pkg::*;

  vflc_cfg_t    cfg;
  vflc_result_t core_res;
  vflc_result_t out_data;
  logic         accept;
  logic         push;
  logic         in_ready;

  // Polarity registers on the APB side
  vflc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance frame state on every byte transfer
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  vflc_frame_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg),
    .push    (push),
    .res     (core_res)
  );

  // Hold finished results until the sink takes them
  vflc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (core_res),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_data  (out_data)
  );

  assign out_ch.frame_status     = out_data.frame_status;
  assign out_ch.command_code     = out_data.command_code;
  assign out_ch.first_on         = out_data.first_on;
  assign out_ch.second_on        = out_data.second_on;
  assign out_ch.first_pin_level  = out_data.first_pin_level;
  assign out_ch.second_pin_level = out_data.second_pin_level;
  assign out_ch.state_changed    = out_data.state_changed;
endmodule

// ===== design/vflc_cfg_regs.sv =====
// APB polarity registers of the voice frame light controller.
module vflc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vflc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output vflc_pkg::vflc_cfg_t           cfg
);
  import vflc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low_first  <= 1'b1;
      cfg.active_low_second <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == REG_ACTIVE_LOW_FIRST) begin
        cfg.active_low_first <= pwdata[0];
      end else begin
        cfg.active_low_second <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACTIVE_LOW_SECOND) begin
      prdata[0] = cfg.active_low_second;
    end else begin
      prdata[0] = cfg.active_low_first;
    end
  end
endmodule

// ===== design/vflc_frame_core.sv =====
// Frame tracking, checksum test and light command decode.
module vflc_frame_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  vflc_pkg::vflc_cfg_t    cfg,
  output logic                   push,
  output vflc_pkg::vflc_result_t res
);
  import vflc_pkg::*;

  logic [2:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_command, held_command_next;
  logic [1:0] light_state, light_state_next;   // bit 0 first, bit 1 second

  logic          frame_done;
  logic [1:0]    set_en, set_val;
  frame_status_t cmd_status;

  // Decode the held command into per-light set enables and values
  always_comb begin
    set_en     = 2'b00;
    set_val    = 2'b00;
    cmd_status = STATUS_LIGHT;
    case (held_command)
      CMD_WAKE, CMD_EXIT: cmd_status = STATUS_NOTICE;
      CMD_FIRST_ON_A, CMD_FIRST_ON_B: begin
        set_en  = 2'b01;
        set_val = 2'b01;
      end
      CMD_FIRST_OFF: set_en = 2'b01;
      CMD_SECOND_OFF: set_en = 2'b10;
      CMD_BOTH_OFF: set_en = 2'b11;
      CMD_BOTH_ON: begin
        set_en  = 2'b11;
        set_val = 2'b11;
      end
      default: cmd_status = STATUS_UNKNOWN;
    endcase
  end

  always_comb begin
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    held_command_next = held_command;
    light_state_next  = light_state;
    frame_done        = 1'b0;
    res.frame_status  = cmd_status;

    if (byte_count == 3'd0) begin
      // Drop bytes until a header shows up
      if (rx_byte == HDR_BYTE) begin
        running_sum_next = rx_byte;
        byte_count_next  = 3'd1;
      end
    end else if (byte_count < FRAME_LAST) begin
      if (byte_count == 3'd1) begin
        held_command_next = rx_byte;
      end
      running_sum_next = running_sum + rx_byte;
      byte_count_next  = byte_count + 3'd1;
    end else begin
      byte_count_next = 3'd0;
      frame_done      = 1'b1;
      if (running_sum != rx_byte) begin
        res.frame_status = STATUS_CSUM_FAIL;
      end else begin
        light_state_next = (set_en & set_val) | (~set_en & light_state);
      end
    end

    res.command_code     = held_command;
    res.first_on         = light_state_next[0];
    res.second_on        = light_state_next[1];
    res.first_pin_level  = light_state_next[0] ^ cfg.active_low_first;
    res.second_pin_level = light_state_next[1] ^ cfg.active_low_second;
    res.state_changed    = light_state_next != light_state;
  end

  assign push = accept && frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= 3'd0;
      running_sum  <= 8'd0;
      held_command <= 8'd0;
      light_state  <= 2'b00;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      running_sum  <= running_sum_next;
      held_command <= held_command_next;
      light_state  <= light_state_next;
    end
  end
endmodule

// ===== design/vflc_out_stage.sv =====
// Result register with one skid entry behind it.
module vflc_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  vflc_pkg::vflc_result_t push_data,
  input  logic                   out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output vflc_pkg::vflc_result_t out_data
);
  import vflc_pkg::*;

  logic         skid_valid;
  vflc_result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      // Output stalled: park a new result in the skid entry
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end
endmodule

// ===== design/vflc_checker.sv =====
// Port-level checks of the voice frame light controller and their binding.
`include "voice_frame_light_controller_assert.svh"

module vflc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] frame_status,
  input logic [7:0] command_code,
  input logic       first_on,
  input logic       second_on,
  input logic       state_changed
);
  import vflc_pkg::*;

  // A stalled result stays offered
  `VFLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A failed checksum never moves a light
  `VFLC_ASSERT_SAME(a_fail_no_change, out_valid && frame_status == STATUS_CSUM_FAIL, !state_changed)

  // Notices and unknown commands never move a light
  `VFLC_ASSERT_SAME(a_other_no_change, out_valid && (frame_status == STATUS_NOTICE || frame_status == STATUS_UNKNOWN), !state_changed)

  // An accepted both-on command leaves both lights on
  `VFLC_ASSERT_SAME(a_both_on, out_valid && frame_status == STATUS_LIGHT && command_code == CMD_BOTH_ON, first_on && second_on)
endmodule

bind voice_frame_light_controller vflc_checker u_vflc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .frame_status  (out_ch.frame_status),
  .command_code  (out_ch.command_code),
  .first_on      (out_ch.first_on),
  .second_on     (out_ch.second_on),
  .state_changed (out_ch.state_changed)
);
